[rtl/sexp_tok_pkg.sv]
`timescale 1ns / 1ps

package sexp_tok_pkg;

  localparam int PositionBitsDefault = 16;

  // result queue: one item may push up to three results in a cycle
  localparam int MaxBurst   = 3;
  localparam int QueueDepth = 8;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharLParen    = 8'h28;
  localparam logic [7:0] CharRParen    = 8'h29;
  localparam logic [7:0] CharUnderbar  = 8'h5F;
  localparam logic [7:0] CharMinus     = 8'h2D;
  localparam logic [7:0] CharStar      = 8'h2A;
  localparam logic [7:0] CharBang      = 8'h21;
  localparam logic [7:0] CharDot       = 8'h2E;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharCr        = 8'h0D;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharLf        = 8'h0A;

  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_NUMBER = 3'd1,
    KIND_STRING = 3'd2,
    KIND_LPAREN = 3'd3,
    KIND_RPAREN = 3'd4,
    KIND_END    = 3'd5,
    KIND_ERROR  = 3'd6
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_INCOMPLETE = 2'd2
  } err_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_SLASH    = 3'd1,
    MODE_COMMENT  = 3'd2,
    MODE_IDENT    = 3'd3,
    MODE_NUMBER   = 3'd4,
    MODE_NUMDOT   = 3'd5,
    MODE_FRACTION = 3'd6,
    MODE_STRING   = 3'd7
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e   kind;
    err_kind_e   err;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } tok_rec_t;

  typedef struct packed {
    logic     valid;
    tok_rec_t rec;
  } tok_slot_t;

  // slot a: pending token, slot b: dot error, slot c: token of the new byte or end
  typedef struct packed {
    tok_slot_t slot_a;
    tok_slot_t slot_b;
    tok_slot_t slot_c;
  } tok_burst_t;

  typedef struct packed {
    scan_mode_e mode;
  } scan_status_t;

  typedef struct packed {
    logic               ready;
    logic [QueueCw-1:0] count;
  } queue_status_t;

  function automatic logic is_dec_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == CharUnderbar) || (b == CharMinus) || (b == CharStar) || (b == CharBang);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CharSpace) || (b == CharCr) || (b == CharTab);
  endfunction

endpackage

[rtl/s_expression_tokenizer.sv]
`timescale 1ns / 1ps
// timing: the results of an item enter the result queue at the edge that accepts it,
//   and the queue head is offered combinationally from the queue memory
// throughput: one text item per cycle while the 8-entry queue has room for three
//   results; results leave at one per cycle while the output is ready, so bursts are bounded by that queue
// reset (asynchronous, active low): idle mode, position 0, line 1, queue empty

module s_expression_tokenizer #(
  parameter int POSITION_BITS = sexp_tok_pkg::PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] text_byte
  input  logic [0:0]  s_tuser_i,   // [0] end_of_text
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,   // [15:0] start_offset, [31:16] token_length,
                                   // [47:32] line_number
  output logic [4:0]  m_tuser_o,   // [2:0] token_kind, [4:3] error_kind
  output logic        m_tlast_o    // last_of_run
);
  import sexp_tok_pkg::*;

  logic          accept;
  tok_burst_t    burst;
  scan_status_t  scan_status;
  queue_status_t queue_status;
  tok_rec_t      head;

  assign s_tready_o = queue_status.ready;
  assign accept     = s_tvalid_i & s_tready_o;

  sexp_tok_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (s_tdata_i),
    .end_of_text_i(s_tuser_i[0]),
    .burst_o      (burst),
    .status_o     (scan_status)
  );

  sexp_tok_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .burst_i    (burst),
    .pop_ready_i(m_tready_i),
    .valid_o    (m_tvalid_o),
    .head_o     (head),
    .status_o   (queue_status)
  );

  assign m_tdata_o = {head.line_number, head.token_length, head.start_offset};
  assign m_tuser_o = {head.err, head.kind};
  assign m_tlast_o = head.last_of_run;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_status.count <= QueueCw'(QueueDepth))
    else $error("result queue overfilled");

  a_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_tuser_i[0] |-> burst.slot_c.valid && burst.slot_c.rec.kind == KIND_END &&
                               burst.slot_c.rec.last_of_run)
    else $error("end of text without a final end token");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_tuser_i[0] |=> scan_status.mode == MODE_IDLE)
    else $error("scanner not idle after end of text");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !accept |=>
      queue_status.count == $past(queue_status.count) - QueueCw'(1))
    else $error("queue count does not follow a lone pop");
`endif

endmodule

[rtl/sexp_tok_scan.sv]
`timescale 1ns / 1ps

module sexp_tok_scan #(
  parameter int POSITION_BITS = sexp_tok_pkg::PositionBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [7:0]                 text_byte_i,
  input  logic                       end_of_text_i,
  output sexp_tok_pkg::tok_burst_t   burst_o,
  output sexp_tok_pkg::scan_status_t status_o
);
  import sexp_tok_pkg::*;

  localparam int P    = POSITION_BITS;
  localparam int ExtW = (P + 1 > 17) ? P + 1 : 17;

  scan_mode_e  mode_q, mode_d;
  logic [P-1:0] pos_q, pos_d;
  logic [P-1:0] start_q, start_d;
  logic [15:0] line_q, line_d;
  logic        bslash_q, bslash_d;

  logic [P:0]   pos_inc;
  logic [P:0]   start_inc;
  logic [P-1:0] dot_raw;
  logic [P-1:0] dot_pos;
  logic         run_idle;
  logic         line_inc;
  tok_burst_t   burst;

  function automatic logic [15:0] sat16(input logic [ExtW-1:0] v);
    return (|v[ExtW-1:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic tok_slot_t mk_slot(input tok_kind_e kind, input err_kind_e err,
                                        input logic [P-1:0] st, input logic [P:0] en,
                                        input logic [15:0] line);
    logic [ExtW-1:0] st_x;
    logic [ExtW-1:0] en_x;
    logic [ExtW-1:0] len_x;
    tok_slot_t       s;
    st_x = ExtW'(st);
    en_x = ExtW'(en);
    len_x = (en_x >= st_x) ? en_x - st_x : '0;
    s.valid = 1'b1;
    s.rec.kind = kind;
    s.rec.err = err;
    s.rec.start_offset = sat16(st_x);
    s.rec.token_length = sat16(len_x);
    s.rec.line_number = line;
    s.rec.last_of_run = 1'b0;
    return s;
  endfunction

  assign pos_inc   = {1'b0, pos_q} + {{P{1'b0}}, 1'b1};
  assign start_inc = {1'b0, start_q} + {{P{1'b0}}, 1'b1};
  // a pending dot sits one byte back, never before the token start
  assign dot_raw   = (pos_q != '0) ? pos_q - {{(P-1){1'b0}}, 1'b1} : '0;
  assign dot_pos   = (dot_raw < start_q) ? start_q : dot_raw;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    bslash_d = bslash_q;
    line_inc = 1'b0;
    run_idle = 1'b0;
    burst    = '0;

    if (end_of_text_i) begin
      case (mode_q)
        MODE_SLASH:
          burst.slot_a = mk_slot(KIND_ERROR, ERR_UNEXPECTED, start_q, start_inc, line_q);
        MODE_IDENT:
          burst.slot_a = mk_slot(KIND_IDENT, ERR_NONE, start_q, {1'b0, pos_q}, line_q);
        MODE_NUMBER, MODE_FRACTION:
          burst.slot_a = mk_slot(KIND_NUMBER, ERR_NONE, start_q, {1'b0, pos_q}, line_q);
        MODE_NUMDOT: begin
          burst.slot_a = mk_slot(KIND_NUMBER, ERR_NONE, start_q, {1'b0, dot_pos}, line_q);
          burst.slot_b = mk_slot(KIND_ERROR, ERR_UNEXPECTED, dot_pos,
                                 {1'b0, dot_pos} + {{P{1'b0}}, 1'b1}, line_q);
        end
        MODE_STRING:
          burst.slot_a = mk_slot(KIND_ERROR, ERR_INCOMPLETE, start_q, {1'b0, pos_q}, line_q);
        default: ;
      endcase
      burst.slot_c = mk_slot(KIND_END, ERR_NONE, pos_q, {1'b0, pos_q}, line_q);
      mode_d   = MODE_IDLE;
      bslash_d = 1'b0;
    end else begin
      case (mode_q)
        MODE_SLASH: begin
          if (text_byte_i == CharSlash) begin
            mode_d = MODE_COMMENT;
          end else begin
            burst.slot_a = mk_slot(KIND_ERROR, ERR_UNEXPECTED, start_q, start_inc, line_q);
            run_idle = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (text_byte_i == CharLf) begin
            line_inc = 1'b1;
            mode_d   = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (!(is_name_char(text_byte_i) || is_dec_digit(text_byte_i))) begin
            burst.slot_a = mk_slot(KIND_IDENT, ERR_NONE, start_q, {1'b0, pos_q}, line_q);
            run_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (text_byte_i == CharDot) begin
            mode_d = MODE_NUMDOT;
          end else if (!is_dec_digit(text_byte_i)) begin
            burst.slot_a = mk_slot(KIND_NUMBER, ERR_NONE, start_q, {1'b0, pos_q}, line_q);
            run_idle = 1'b1;
          end
        end
        MODE_NUMDOT: begin
          if (is_dec_digit(text_byte_i)) begin
            mode_d = MODE_FRACTION;
          end else begin
            burst.slot_a = mk_slot(KIND_NUMBER, ERR_NONE, start_q, {1'b0, dot_pos}, line_q);
            burst.slot_b = mk_slot(KIND_ERROR, ERR_UNEXPECTED, dot_pos,
                                   {1'b0, dot_pos} + {{P{1'b0}}, 1'b1}, line_q);
            run_idle = 1'b1;
          end
        end
        MODE_FRACTION: begin
          if (!is_dec_digit(text_byte_i)) begin
            burst.slot_a = mk_slot(KIND_NUMBER, ERR_NONE, start_q, {1'b0, pos_q}, line_q);
            run_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (text_byte_i == CharLf) line_inc = 1'b1;
          if ((text_byte_i == CharQuote) && !bslash_q) begin
            burst.slot_a = mk_slot(KIND_STRING, ERR_NONE, start_q, pos_inc, line_q);
            mode_d   = MODE_IDLE;
            bslash_d = 1'b0;
          end else begin
            bslash_d = (text_byte_i == CharBackslash);
          end
        end
        default: run_idle = 1'b1;
      endcase

      // the byte is scanned afresh with no token pending
      if (run_idle) begin
        mode_d = MODE_IDLE;
        if (is_blank(text_byte_i)) begin
          mode_d = MODE_IDLE;
        end else if (text_byte_i == CharLf) begin
          line_inc = 1'b1;
        end else begin
          start_d = pos_q;
          if (text_byte_i == CharSlash) begin
            mode_d = MODE_SLASH;
          end else if (is_dec_digit(text_byte_i)) begin
            mode_d = MODE_NUMBER;
          end else if (text_byte_i == CharLParen) begin
            burst.slot_c = mk_slot(KIND_LPAREN, ERR_NONE, pos_q, pos_inc, line_q);
          end else if (text_byte_i == CharRParen) begin
            burst.slot_c = mk_slot(KIND_RPAREN, ERR_NONE, pos_q, pos_inc, line_q);
          end else if (text_byte_i == CharQuote) begin
            bslash_d = 1'b0;
            mode_d   = MODE_STRING;
          end else if (is_name_char(text_byte_i)) begin
            mode_d = MODE_IDENT;
          end else begin
            burst.slot_c = mk_slot(KIND_ERROR, ERR_UNEXPECTED, pos_q, pos_inc, line_q);
          end
        end
      end
    end

    burst.slot_c.rec.last_of_run = burst.slot_c.valid;
    burst.slot_b.rec.last_of_run = burst.slot_b.valid & ~burst.slot_c.valid;
    burst.slot_a.rec.last_of_run = burst.slot_a.valid & ~burst.slot_b.valid &
                                   ~burst.slot_c.valid;
  end

  assign line_d = (line_inc && (line_q != 16'hFFFF)) ? line_q + 16'd1 : line_q;
  assign pos_d  = (!end_of_text_i && (pos_q != '1)) ? pos_inc[P-1:0] : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      line_q   <= 16'd1;
      bslash_q <= 1'b0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      line_q   <= line_d;
      bslash_q <= bslash_d;
    end
  end

  assign burst_o       = burst;
  assign status_o.mode = mode_q;

endmodule

[rtl/sexp_tok_queue.sv]
`timescale 1ns / 1ps

module sexp_tok_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  sexp_tok_pkg::tok_burst_t    burst_i,
  input  logic                        pop_ready_i,
  output logic                        valid_o,
  output sexp_tok_pkg::tok_rec_t      head_o,
  output sexp_tok_pkg::queue_status_t status_o
);
  import sexp_tok_pkg::*;

  tok_rec_t mem_q [QueueDepth];

  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCw-1:0] count_q, count_d;
  logic [1:0]         n_ab;
  logic [1:0]         n_all;
  logic [QueueAw-1:0] addr_b;
  logic [QueueAw-1:0] addr_c;
  logic               pop;
  logic [1:0]         n_push;

  assign n_ab   = {1'b0, burst_i.slot_a.valid} + {1'b0, burst_i.slot_b.valid};
  assign n_all  = n_ab + {1'b0, burst_i.slot_c.valid};
  assign n_push = push_i ? n_all : 2'd0;
  // results are packed in order a, b, c with empty slots squeezed out
  assign addr_b = wr_ptr_q + QueueAw'(1);
  assign addr_c = wr_ptr_q + QueueAw'(n_ab);
  assign pop    = valid_o & pop_ready_i;

  assign wr_ptr_d = wr_ptr_q + QueueAw'(n_push);
  assign rd_ptr_d = rd_ptr_q + QueueAw'(pop);
  assign count_d  = count_q + QueueCw'(n_push) - QueueCw'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (burst_i.slot_a.valid) mem_q[wr_ptr_q] <= burst_i.slot_a.rec;
      if (burst_i.slot_b.valid) mem_q[addr_b] <= burst_i.slot_b.rec;
      if (burst_i.slot_c.valid) mem_q[addr_c] <= burst_i.slot_c.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o        = (count_q != '0);
  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.ready = (count_q <= QueueCw'(QueueDepth - MaxBurst));

endmodule
